[rtl/cpcr_pkg.sv]
// Shared types, widths and helper functions for the circle pair collision resolver.
package cpcr_pkg;

    localparam int WORD_W = 24;
    localparam int FRAC_W = 12;
    localparam int RAD_W  = 19;
    localparam int DAMP_W = 13;

    localparam int DIFF_W = WORD_W + 1;
    localparam int MAG_W  = WORD_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int RS_W   = RAD_W + 1;
    localparam int R2_W   = 2 * RS_W;
    localparam int REM_W  = RS_W + 3;
    localparam int QB_W   = FRAC_W + 1;
    localparam int NRM_W  = FRAC_W + 2;
    localparam int PEN_W  = RS_W + 1;
    localparam int PX_W   = PEN_W + NRM_W;
    localparam int DP_W   = DIFF_W + NRM_W;
    localparam int DOT_W  = DP_W + 1;
    localparam int VN_W   = DOT_W - FRAC_W;
    localparam int G_W    = DAMP_W + 2;
    localparam int Q_W    = VN_W + G_W;
    localparam int J_W    = Q_W - FRAC_W;
    localparam int IJ_W   = J_W + NRM_W;
    localparam int SAT_W  = IJ_W;

    localparam int ONE = 1 << FRAC_W;

    // squared distance at or below this means the centers coincide
    localparam logic [D2_W-1:0] EPS_DIST2 = D2_W'((64'd1 << (2 * FRAC_W)) / 64'd10000);

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (WORD_W - 1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(2 ** (WORD_W - 1)));

    typedef struct packed {
        logic signed [WORD_W-1:0] a_pos_x;
        logic signed [WORD_W-1:0] a_pos_y;
        logic signed [WORD_W-1:0] a_vel_x;
        logic signed [WORD_W-1:0] a_vel_y;
        logic        [RAD_W-1:0]  a_radius;
        logic        [DAMP_W-1:0] a_damping;
        logic signed [WORD_W-1:0] b_pos_x;
        logic signed [WORD_W-1:0] b_pos_y;
        logic signed [WORD_W-1:0] b_vel_x;
        logic signed [WORD_W-1:0] b_vel_y;
        logic        [RAD_W-1:0]  b_radius;
        logic        [DAMP_W-1:0] b_damping;
    } t_in;

    typedef struct packed {
        logic                     collided;
        logic signed [WORD_W-1:0] new_a_pos_x;
        logic signed [WORD_W-1:0] new_a_pos_y;
        logic signed [WORD_W-1:0] new_a_vel_x;
        logic signed [WORD_W-1:0] new_a_vel_y;
        logic signed [WORD_W-1:0] new_b_pos_x;
        logic signed [WORD_W-1:0] new_b_pos_y;
        logic signed [WORD_W-1:0] new_b_vel_x;
        logic signed [WORD_W-1:0] new_b_vel_y;
    } t_out;

    // per-item context carried down the pipeline
    typedef struct packed {
        logic signed [WORD_W-1:0] ax;
        logic signed [WORD_W-1:0] ay;
        logic signed [WORD_W-1:0] avx;
        logic signed [WORD_W-1:0] avy;
        logic signed [WORD_W-1:0] bx;
        logic signed [WORD_W-1:0] by;
        logic signed [WORD_W-1:0] bvx;
        logic signed [WORD_W-1:0] bvy;
        logic signed [DIFF_W-1:0] dvx;
        logic signed [DIFF_W-1:0] dvy;
        logic        [RS_W-1:0]   r;
        logic        [DAMP_W-1:0] e;
        logic                     dxn;
        logic                     dyn;
        logic        [RS_W-1:0]   mdx;
        logic        [RS_W-1:0]   mdy;
        logic                     hit;
        logic                     near;
        logic                     neg;
    } t_ctx;

    // arithmetic shift right rounding toward zero
    function automatic logic signed [63:0] shr0(input logic signed [63:0] v, input int sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = m >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [WORD_W-1:0] sat(input logic signed [SAT_W-1:0] v);
        logic signed [WORD_W-1:0] res;
        if (v > SAT_HI) begin
            res = WORD_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = WORD_W'(SAT_LO);
        end else begin
            res = WORD_W'(v);
        end
        return res;
    endfunction

endpackage

[rtl/cpcr_ifs.sv]
// Valid/ready channel interfaces for circle pairs in and resolved pairs out.
interface cpcr_in_if;
    logic             valid;
    logic             ready;
    cpcr_pkg::t_in    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpcr_out_if;
    logic             valid;
    logic             ready;
    cpcr_pkg::t_out   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/circle_pair_collision_resolve_unit.sv]
// Pipeline: setup stages A, B and C, the square root, the restoring divide, then resolve stages M1 to M5.
// Throughput: one item per cycle while the output is taken; the whole pipeline advances in lockstep.
// Stall: when the output register holds an untaken item, every stage holds.
// Reset: synchronous active-low i_rst_n clears all valid bits; data regs are not reset.
module circle_pair_collision_resolve_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpcr_in_if.sink     i_in,
    cpcr_out_if.source  o_out
);

    localparam int WORD_W = cpcr_pkg::WORD_W;
    localparam int FRAC_W = cpcr_pkg::FRAC_W;
    localparam int DIFF_W = cpcr_pkg::DIFF_W;
    localparam int MAG_W  = cpcr_pkg::MAG_W;
    localparam int SQ_W   = cpcr_pkg::SQ_W;
    localparam int D2_W   = cpcr_pkg::D2_W;
    localparam int RS_W   = cpcr_pkg::RS_W;
    localparam int R2_W   = cpcr_pkg::R2_W;
    localparam int REM_W  = cpcr_pkg::REM_W;
    localparam int QB_W   = cpcr_pkg::QB_W;
    localparam int NRM_W  = cpcr_pkg::NRM_W;
    localparam int PEN_W  = cpcr_pkg::PEN_W;
    localparam int PX_W   = cpcr_pkg::PX_W;
    localparam int DP_W   = cpcr_pkg::DP_W;
    localparam int DOT_W  = cpcr_pkg::DOT_W;
    localparam int VN_W   = cpcr_pkg::VN_W;
    localparam int G_W    = cpcr_pkg::G_W;
    localparam int Q_W    = cpcr_pkg::Q_W;
    localparam int J_W    = cpcr_pkg::J_W;
    localparam int IJ_W   = cpcr_pkg::IJ_W;
    localparam int SAT_W  = cpcr_pkg::SAT_W;

    localparam int ST_C   = 2;
    localparam int ST_SQ0 = 3;
    localparam int ST_DV0 = ST_SQ0 + RS_W;
    localparam int ST_M1  = ST_DV0 + QB_W;
    localparam int ST_M2  = ST_M1 + 1;
    localparam int ST_M3  = ST_M2 + 1;
    localparam int ST_M4  = ST_M3 + 1;
    localparam int ST_M5  = ST_M4 + 1;
    localparam int NST    = ST_M5 + 1;

    logic adv;
    logic [NST-1:0] r_vld;
    cpcr_pkg::t_ctx r_ctx [NST];
    cpcr_pkg::t_ctx n_ctx [NST];

    assign adv         = !r_vld[NST-1] || o_out.ready;
    assign i_in.ready  = adv;
    assign o_out.valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctx <= n_ctx;
        end
    end

    // ---------------- stage A: differences ----------------
    logic signed [DIFF_W-1:0] n_dx, n_dy;
    logic [MAG_W-1:0] r_a_mdx, r_a_mdy;

    assign n_dx = DIFF_W'(i_in.data.a_pos_x) - DIFF_W'(i_in.data.b_pos_x);
    assign n_dy = DIFF_W'(i_in.data.a_pos_y) - DIFF_W'(i_in.data.b_pos_y);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_mdx <= n_dx[DIFF_W-1] ? MAG_W'(-n_dx) : MAG_W'(n_dx);
            r_a_mdy <= n_dy[DIFF_W-1] ? MAG_W'(-n_dy) : MAG_W'(n_dy);
        end
    end

    // ---------------- stage B: squares ----------------
    logic [SQ_W-1:0] r_b_sqx, r_b_sqy;
    logic [R2_W-1:0] r_b_r2;
    logic [RS_W-1:0] r_b_mdx, r_b_mdy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_sqx <= SQ_W'(r_a_mdx) * SQ_W'(r_a_mdx);
            r_b_sqy <= SQ_W'(r_a_mdy) * SQ_W'(r_a_mdy);
            r_b_r2  <= R2_W'(r_ctx[0].r) * R2_W'(r_ctx[0].r);
            r_b_mdx <= r_a_mdx[RS_W-1:0];
            r_b_mdy <= r_a_mdy[RS_W-1:0];
        end
    end

    // ---------------- stage C: overlap test ----------------
    logic [D2_W-1:0] n_d2;
    logic [R2_W-1:0] r_c_x;

    assign n_d2 = D2_W'(r_b_sqx) + D2_W'(r_b_sqy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_x <= n_d2[R2_W-1:0];
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [R2_W-1:0]  r_sq_x    [RS_W-1];
    logic [REM_W-1:0] r_sq_rem  [RS_W-1];
    logic [RS_W-1:0]  r_sq_root [RS_W];

    for (genvar k = 0; k < RS_W; k++) begin : g_sq
        logic [R2_W-1:0]  x_in;
        logic [REM_W-1:0] rem_in, rem_sh, trial;
        logic [RS_W-1:0]  root_in;
        logic             ge;

        if (k == 0) begin : g_first
            assign x_in    = r_c_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_sq_x[k-1];
            assign rem_in  = r_sq_rem[k-1];
            assign root_in = r_sq_root[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], x_in[2*(RS_W-1-k)+1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_root[k] <= {root_in[RS_W-2:0], ge};
            end
        end

        if (k < RS_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sq_x[k]   <= x_in;
                    r_sq_rem[k] <= ge ? rem_sh - trial : rem_sh;
                end
            end
        end
    end

    // ---------------- restoring divide for both normal components ----------------
    logic [RS_W-1:0] r_dv_dist [QB_W];
    logic [QB_W-1:0] r_dv_qx   [QB_W];
    logic [QB_W-1:0] r_dv_qy   [QB_W];
    logic [RS_W-1:0] r_dv_rx   [QB_W-1];
    logic [RS_W-1:0] r_dv_ry   [QB_W-1];

    for (genvar k = 0; k < QB_W; k++) begin : g_dv
        logic [RS_W-1:0] dist_in;
        logic [RS_W:0]   rx_in, ry_in, dext;
        logic [QB_W-1:0] qx_in, qy_in;
        logic            gx, gy;

        if (k == 0) begin : g_first
            assign dist_in = r_sq_root[RS_W-1];
            assign rx_in   = {1'b0, r_ctx[ST_DV0-1].mdx};
            assign ry_in   = {1'b0, r_ctx[ST_DV0-1].mdy};
            assign qx_in   = '0;
            assign qy_in   = '0;
        end else begin : g_next
            assign dist_in = r_dv_dist[k-1];
            assign rx_in   = {r_dv_rx[k-1], 1'b0};
            assign ry_in   = {r_dv_ry[k-1], 1'b0};
            assign qx_in   = r_dv_qx[k-1];
            assign qy_in   = r_dv_qy[k-1];
        end

        assign dext = {1'b0, dist_in};
        assign gx   = rx_in >= dext;
        assign gy   = ry_in >= dext;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_dist[k] <= dist_in;
                r_dv_qx[k]   <= {qx_in[QB_W-2:0], gx};
                r_dv_qy[k]   <= {qy_in[QB_W-2:0], gy};
            end
        end

        if (k < QB_W - 1) begin : g_keep
            logic [RS_W:0] nrx, nry;
            assign nrx = gx ? rx_in - dext : rx_in;
            assign nry = gy ? ry_in - dext : ry_in;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dv_rx[k] <= nrx[RS_W-1:0];
                    r_dv_ry[k] <= nry[RS_W-1:0];
                end
            end
        end
    end

    // ---------------- M1: signed normal, penetration, products ----------------
    logic signed [NRM_W-1:0] n_m1_nx, n_m1_ny, qxs, qys;
    logic signed [PEN_W-1:0] n_m1_pen;
    logic signed [NRM_W-1:0] r_m1_nx, r_m1_ny;
    logic signed [PX_W-1:0]  r_m1_px, r_m1_py;
    logic signed [DP_W-1:0]  r_m1_dpx, r_m1_dpy;

    always_comb begin
        qxs = $signed(NRM_W'(r_dv_qx[QB_W-1]));
        qys = $signed(NRM_W'(r_dv_qy[QB_W-1]));
        if (r_ctx[ST_M1-1].near) begin
            n_m1_nx  = '0;
            n_m1_ny  = NRM_W'(cpcr_pkg::ONE);
            n_m1_pen = $signed(PEN_W'(r_ctx[ST_M1-1].r));
        end else begin
            n_m1_nx  = r_ctx[ST_M1-1].dxn ? -qxs : qxs;
            n_m1_ny  = r_ctx[ST_M1-1].dyn ? -qys : qys;
            n_m1_pen = $signed(PEN_W'(r_ctx[ST_M1-1].r))
                     - $signed(PEN_W'(r_dv_dist[QB_W-1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_nx  <= n_m1_nx;
            r_m1_ny  <= n_m1_ny;
            r_m1_px  <= n_m1_nx * n_m1_pen;
            r_m1_py  <= n_m1_ny * n_m1_pen;
            r_m1_dpx <= r_ctx[ST_M1-1].dvx * n_m1_nx;
            r_m1_dpy <= r_ctx[ST_M1-1].dvy * n_m1_ny;
        end
    end

    // ---------------- M2: separation, relative normal velocity ----------------
    logic signed [SAT_W-1:0] n_m2_sx, n_m2_sy;
    logic signed [NRM_W-1:0] r_m2_nx, r_m2_ny;
    logic signed [DOT_W-1:0] r_m2_dot;

    assign n_m2_sx = SAT_W'(cpcr_pkg::shr0(64'(r_m1_px), FRAC_W + 1));
    assign n_m2_sy = SAT_W'(cpcr_pkg::shr0(64'(r_m1_py), FRAC_W + 1));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m2_nx  <= r_m1_nx;
            r_m2_ny  <= r_m1_ny;
            r_m2_dot <= DOT_W'(r_m1_dpx) + DOT_W'(r_m1_dpy);
        end
    end

    // ---------------- M3: scale by (1 + min damping) ----------------
    logic signed [VN_W-1:0]  n_m3_vn;
    logic signed [G_W-1:0]   n_m3_g;
    logic signed [NRM_W-1:0] r_m3_nx, r_m3_ny;
    logic signed [Q_W-1:0]   r_m3_q;

    assign n_m3_vn = VN_W'(cpcr_pkg::shr0(64'(r_m2_dot), FRAC_W));
    assign n_m3_g  = G_W'(cpcr_pkg::ONE) + G_W'(r_ctx[ST_M3-1].e);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m3_nx <= r_m2_nx;
            r_m3_ny <= r_m2_ny;
            r_m3_q  <= n_m3_g * n_m3_vn;
        end
    end

    // ---------------- M4: impulse along the normal ----------------
    logic signed [J_W-1:0]  n_m4_j;
    logic signed [IJ_W-1:0] r_m4_ix, r_m4_iy;

    assign n_m4_j = -J_W'(cpcr_pkg::shr0(64'(r_m3_q), FRAC_W + 1));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m4_ix <= n_m4_j * r_m3_nx;
            r_m4_iy <= n_m4_j * r_m3_ny;
        end
    end

    // ---------------- M5: apply impulse ----------------
    logic signed [SAT_W-1:0] n_m5_ix, n_m5_iy;

    assign n_m5_ix = SAT_W'(cpcr_pkg::shr0(64'(r_m4_ix), FRAC_W));
    assign n_m5_iy = SAT_W'(cpcr_pkg::shr0(64'(r_m4_iy), FRAC_W));

    // ---------------- context next values ----------------
    always_comb begin
        n_ctx[0].ax   = i_in.data.a_pos_x;
        n_ctx[0].ay   = i_in.data.a_pos_y;
        n_ctx[0].avx  = i_in.data.a_vel_x;
        n_ctx[0].avy  = i_in.data.a_vel_y;
        n_ctx[0].bx   = i_in.data.b_pos_x;
        n_ctx[0].by   = i_in.data.b_pos_y;
        n_ctx[0].bvx  = i_in.data.b_vel_x;
        n_ctx[0].bvy  = i_in.data.b_vel_y;
        n_ctx[0].dvx  = DIFF_W'(i_in.data.a_vel_x) - DIFF_W'(i_in.data.b_vel_x);
        n_ctx[0].dvy  = DIFF_W'(i_in.data.a_vel_y) - DIFF_W'(i_in.data.b_vel_y);
        n_ctx[0].r    = RS_W'(i_in.data.a_radius) + RS_W'(i_in.data.b_radius);
        n_ctx[0].e    = (i_in.data.a_damping < i_in.data.b_damping) ?
                        i_in.data.a_damping : i_in.data.b_damping;
        n_ctx[0].dxn  = n_dx[DIFF_W-1];
        n_ctx[0].dyn  = n_dy[DIFF_W-1];
        n_ctx[0].mdx  = '0;
        n_ctx[0].mdy  = '0;
        n_ctx[0].hit  = 1'b0;
        n_ctx[0].near = 1'b0;
        n_ctx[0].neg  = 1'b0;

        for (int i = 1; i < NST; i++) begin
            n_ctx[i] = r_ctx[i-1];
        end

        n_ctx[ST_C].mdx  = r_b_mdx;
        n_ctx[ST_C].mdy  = r_b_mdy;
        n_ctx[ST_C].hit  = n_d2 < D2_W'(r_b_r2);
        n_ctx[ST_C].near = n_d2 <= cpcr_pkg::EPS_DIST2;

        if (r_ctx[ST_M2-1].hit) begin
            n_ctx[ST_M2].ax = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M2-1].ax) + n_m2_sx);
            n_ctx[ST_M2].ay = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M2-1].ay) + n_m2_sy);
            n_ctx[ST_M2].bx = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M2-1].bx) - n_m2_sx);
            n_ctx[ST_M2].by = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M2-1].by) - n_m2_sy);
        end

        n_ctx[ST_M3].neg = r_m2_dot[DOT_W-1];

        // impulse only when the pair is approaching
        if (r_ctx[ST_M5-1].hit && r_ctx[ST_M5-1].neg) begin
            n_ctx[ST_M5].avx = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M5-1].avx) + n_m5_ix);
            n_ctx[ST_M5].avy = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M5-1].avy) + n_m5_iy);
            n_ctx[ST_M5].bvx = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M5-1].bvx) - n_m5_ix);
            n_ctx[ST_M5].bvy = cpcr_pkg::sat(SAT_W'(r_ctx[ST_M5-1].bvy) - n_m5_iy);
        end
    end

    // ---------------- output ----------------
    assign o_out.data.collided    = r_ctx[NST-1].hit;
    assign o_out.data.new_a_pos_x = r_ctx[NST-1].ax;
    assign o_out.data.new_a_pos_y = r_ctx[NST-1].ay;
    assign o_out.data.new_a_vel_x = r_ctx[NST-1].avx;
    assign o_out.data.new_a_vel_y = r_ctx[NST-1].avy;
    assign o_out.data.new_b_pos_x = r_ctx[NST-1].bx;
    assign o_out.data.new_b_pos_y = r_ctx[NST-1].by;
    assign o_out.data.new_b_vel_x = r_ctx[NST-1].bvx;
    assign o_out.data.new_b_vel_y = r_ctx[NST-1].bvy;

endmodule

[tb/sv/tb_top.sv]
// Testbench for the circle pair collision resolver: directed and random pairs, scoreboarded.
`timescale 1ns / 100ps
module tb_top;

    typedef cpcr_pkg::t_in  t_in;
    typedef cpcr_pkg::t_out t_out;

    localparam int WORD_W = cpcr_pkg::WORD_W;
    localparam int FRAC_W = cpcr_pkg::FRAC_W;
    localparam int RAD_W  = cpcr_pkg::RAD_W;
    localparam int DAMP_W = cpcr_pkg::DAMP_W;
    localparam int RS_W   = cpcr_pkg::RS_W;
    localparam int ONE    = cpcr_pkg::ONE;
    localparam logic [cpcr_pkg::D2_W-1:0] EPS_DIST2 = cpcr_pkg::EPS_DIST2;

    localparam int LATENCY   = 41;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1130;
    localparam int EXP_DEPTH = 4096;

    logic i_clk;
    logic i_rst_n;

    cpcr_in_if  in_ch ();
    cpcr_out_if out_ch ();

    circle_pair_collision_resolve_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // expected results in send order
    t_out exp_mem [EXP_DEPTH];
    int   wr_ptr;
    int   rd_ptr;
    int   n_errors;
    int   n_sent;
    int   n_hits;
    int   n_recv;
    int   idle_cycles;
    bit   sink_free;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v, input int sh);
        logic [63:0] m;
        m = v < 0 ? 64'(-v) : 64'(v);
        m = m >> sh;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp_word(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'h7fffff;
        if (v < -64'sd8388608) return 24'h800000;
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_out resolve_pair(input t_in p);
        t_out o;
        logic signed [63:0] ax, ay, avx, avy, bx, by, bvx, bvy;
        logic signed [63:0] dx, dy, nx, ny, pen, sx, sy, dot, e, vn, j, ix, iy;
        logic [63:0] mx, my, d2, r, r2, root_d;
        ax = p.a_pos_x;  ay = p.a_pos_y;  avx = p.a_vel_x;  avy = p.a_vel_y;
        bx = p.b_pos_x;  by = p.b_pos_y;  bvx = p.b_vel_x;  bvy = p.b_vel_y;
        o.collided = 1'b0;
        dx = ax - bx;
        dy = ay - by;
        mx = dx < 0 ? 64'(-dx) : 64'(dx);
        my = dy < 0 ? 64'(-dy) : 64'(dy);
        d2 = mx * mx + my * my;     // at most 2^51, no wrap
        r = 64'(p.a_radius) + 64'(p.b_radius);
        r2 = r * r;
        if (d2 < r2) begin
            o.collided = 1'b1;
            if (d2 > 64'(EPS_DIST2)) begin
                root_d = int_sqrt(d2);
                if (root_d == 0) root_d = 1;
                pen = $signed(r) - $signed(root_d);
                nx = $signed((mx << FRAC_W) / root_d);
                ny = $signed((my << FRAC_W) / root_d);
                if (dx < 0) nx = -nx;
                if (dy < 0) ny = -ny;
            end else begin
                pen = $signed(r);
                nx = 0;
                ny = ONE;
            end
            sx = trunc_shr(nx * pen, FRAC_W + 1);
            sy = trunc_shr(ny * pen, FRAC_W + 1);
            ax = clamp_word(ax + sx);
            ay = clamp_word(ay + sy);
            bx = clamp_word(bx - sx);
            by = clamp_word(by - sy);
            dot = (avx - bvx) * nx + (avy - bvy) * ny;
            // impulse only while approaching
            if (dot < 0) begin
                e = p.a_damping < p.b_damping ? 64'(p.a_damping) : 64'(p.b_damping);
                vn = trunc_shr(dot, FRAC_W);
                j = -trunc_shr((ONE + e) * vn, FRAC_W + 1);
                ix = trunc_shr(j * nx, FRAC_W);
                iy = trunc_shr(j * ny, FRAC_W);
                avx = clamp_word(avx + ix);
                avy = clamp_word(avy + iy);
                bvx = clamp_word(bvx - ix);
                bvy = clamp_word(bvy - iy);
            end
        end
        o.new_a_pos_x = ax[WORD_W-1:0];
        o.new_a_pos_y = ay[WORD_W-1:0];
        o.new_a_vel_x = avx[WORD_W-1:0];
        o.new_a_vel_y = avy[WORD_W-1:0];
        o.new_b_pos_x = bx[WORD_W-1:0];
        o.new_b_pos_y = by[WORD_W-1:0];
        o.new_b_vel_x = bvx[WORD_W-1:0];
        o.new_b_vel_y = bvy[WORD_W-1:0];
        return o;
    endfunction

    task automatic send_pair(input t_in p);
        int gap;
        t_out want;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= p;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        want = resolve_pair(p);
        exp_mem[wr_ptr % EXP_DEPTH] = want;
        wr_ptr++;
        if (want.collided) n_hits++;
        n_sent++;
    endtask

    // sink side: random stall per item, including stretches with none
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 11);
            if (sink_free) stall = 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            n_recv++;
            if (wr_ptr == rd_ptr) begin
                $error("unexpected result item");
                n_errors++;
            end else begin
                want = exp_mem[rd_ptr % EXP_DEPTH];
                rd_ptr++;
                if (got.collided !== want.collided) begin
                    $error("collided exp %0d got %0d", want.collided, got.collided);
                    n_errors++;
                end
                if (got.new_a_pos_x !== want.new_a_pos_x) begin
                    $error("new_a_pos_x exp %0d got %0d", want.new_a_pos_x, got.new_a_pos_x);
                    n_errors++;
                end
                if (got.new_a_pos_y !== want.new_a_pos_y) begin
                    $error("new_a_pos_y exp %0d got %0d", want.new_a_pos_y, got.new_a_pos_y);
                    n_errors++;
                end
                if (got.new_a_vel_x !== want.new_a_vel_x) begin
                    $error("new_a_vel_x exp %0d got %0d", want.new_a_vel_x, got.new_a_vel_x);
                    n_errors++;
                end
                if (got.new_a_vel_y !== want.new_a_vel_y) begin
                    $error("new_a_vel_y exp %0d got %0d", want.new_a_vel_y, got.new_a_vel_y);
                    n_errors++;
                end
                if (got.new_b_pos_x !== want.new_b_pos_x) begin
                    $error("new_b_pos_x exp %0d got %0d", want.new_b_pos_x, got.new_b_pos_x);
                    n_errors++;
                end
                if (got.new_b_pos_y !== want.new_b_pos_y) begin
                    $error("new_b_pos_y exp %0d got %0d", want.new_b_pos_y, got.new_b_pos_y);
                    n_errors++;
                end
                if (got.new_b_vel_x !== want.new_b_vel_x) begin
                    $error("new_b_vel_x exp %0d got %0d", want.new_b_vel_x, got.new_b_vel_x);
                    n_errors++;
                end
                if (got.new_b_vel_y !== want.new_b_vel_y) begin
                    $error("new_b_vel_y exp %0d got %0d", want.new_b_vel_y, got.new_b_vel_y);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [WORD_W-1:0] rand_word();
        return WORD_W'($urandom);
    endfunction

    function automatic t_in base_pair();
        t_in p;
        p = '0;
        p.a_radius  = 19'd4096;
        p.b_radius  = 19'd4096;
        p.a_damping = 13'd2048;
        p.b_damping = 13'd2048;
        return p;
    endfunction

    task automatic test_directed();
        t_in p;
        // separated pair, no overlap
        p = base_pair(); p.a_pos_x = 24'sd40000; send_pair(p);
        // head-on approach along x
        p = base_pair(); p.a_pos_x = 24'sd4096; p.a_vel_x = -24'sd8192;
        p.b_vel_x = 24'sd8192; send_pair(p);
        // separating along x: no impulse
        p.a_vel_x = 24'sd8192; p.b_vel_x = -24'sd8192; send_pair(p);
        // resting, dot exactly zero
        p.a_vel_x = '0; p.b_vel_x = '0; send_pair(p);
        // coincident centers
        p = base_pair(); p.a_vel_y = -24'sd4096; send_pair(p);
        // nearly coincident, within the epsilon
        p = base_pair(); p.a_pos_x = 24'sd1; p.a_pos_y = 24'sd1; send_pair(p);
        // zero radii never overlap, then a radius of one on coincident centers
        p = '0; send_pair(p);
        p.a_radius = 19'd1; send_pair(p);
        // damping of a above one, min picks b
        p = base_pair(); p.a_pos_y = -24'sd3000; p.a_vel_y = 24'sd8388607;
        p.b_vel_y = -24'sd8388608; p.a_damping = 13'h1fff; p.b_damping = 13'd4096;
        send_pair(p);
        // largest radii, saturation at the corners
        p = base_pair(); p.a_radius = 19'h7ffff; p.b_radius = 19'h7ffff;
        p.a_pos_x = 24'sd8388607; p.b_pos_x = 24'sd8300000;
        p.a_pos_y = -24'sd8388608; p.b_pos_y = -24'sd8388000;
        p.a_vel_x = -24'sd8388608; p.b_vel_x = 24'sd8388607;
        p.a_damping = 13'h1fff; p.b_damping = 13'h1fff; send_pair(p);
        // far apart extremes
        p.a_pos_x = -24'sd8388608; p.b_pos_x = 24'sd8388607;
        p.a_pos_y = 24'sd8388607; p.b_pos_y = -24'sd8388608; send_pair(p);
        // all ones
        p = '1; send_pair(p);
        // diagonal approach, damping zero
        p = base_pair(); p.a_pos_x = 24'sd3000; p.a_pos_y = 24'sd3000;
        p.a_vel_x = -24'sd5000; p.a_vel_y = -24'sd7000; p.a_damping = '0; send_pair(p);
        p.a_pos_x = -24'sd3000; p.a_vel_x = 24'sd5000; send_pair(p);
    endtask

    task automatic test_idle_drain();
        // hold off until the pipeline is empty, then resume
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (wr_ptr != rd_ptr) @(posedge i_clk);
    endtask

    task automatic test_random();
        t_in p;
        int kind;
        logic [RS_W-1:0] rs;
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            p.a_vel_x = rand_word(); p.a_vel_y = rand_word();
            p.b_vel_x = rand_word(); p.b_vel_y = rand_word();
            p.a_damping = (kind == 0) ? DAMP_W'($urandom) : DAMP_W'($urandom_range(0, 4096));
            p.b_damping = (kind == 1) ? DAMP_W'($urandom) : DAMP_W'($urandom_range(0, 4096));
            if (kind < 7) begin
                // near pairs: mostly overlapping, modest sizes
                p.a_radius = (kind == 2) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 65536));
                p.b_radius = (kind == 3) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 65536));
                rs = RS_W'(p.a_radius) + RS_W'(p.b_radius) + RS_W'(1);
                p.a_pos_x = rand_word();
                p.a_pos_y = rand_word();
                p.b_pos_x = p.a_pos_x - $signed(WORD_W'($urandom_range(0, rs)))
                          + $signed(WORD_W'(rs >> 1));
                p.b_pos_y = p.a_pos_y - $signed(WORD_W'($urandom_range(0, rs)))
                          + $signed(WORD_W'(rs >> 1));
                if (kind == 4) begin
                    p.b_pos_x = p.a_pos_x + $signed(WORD_W'($urandom_range(0, 80))) - 24'sd40;
                    p.b_pos_y = p.a_pos_y + $signed(WORD_W'($urandom_range(0, 80))) - 24'sd40;
                end
                if (kind == 5) begin
                    p.a_vel_x = $signed(WORD_W'($urandom_range(0, 65536))) - 24'sd32768;
                    p.b_vel_x = $signed(WORD_W'($urandom_range(0, 65536))) - 24'sd32768;
                end
            end else begin
                p.a_pos_x = rand_word(); p.a_pos_y = rand_word();
                p.b_pos_x = rand_word(); p.b_pos_y = rand_word();
                p.a_radius = RAD_W'($urandom); p.b_radius = RAD_W'($urandom);
            end
            send_pair(p);
            if (i == N_RANDOM / 2) test_idle_drain();
            // short bursts where the sink never stalls
            if (i % 200 == 0) sink_free = ~sink_free;
        end
        sink_free = 1'b0;
    endtask

    initial begin
        n_sent = 0; n_hits = 0;
        sink_free = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_idle_drain();
        test_random();
        test_idle_drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d circle pairs, %0d overlapping, %0d results checked",
                 n_sent, n_hits, n_recv);
        $display("covered: separation, coincident centers, approach and rest, saturation");
        if (n_errors == 0 && wr_ptr == rd_ptr) begin
            $display("[ OK ] regression clean");
        end else begin
            if (wr_ptr != rd_ptr) $error("%0d results never arrived", wr_ptr - rd_ptr);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
